// File: hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the software timer pool and its cells.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned SlotsDefault     = 8;
  localparam int unsigned LimitBitsDefault = 24;
  localparam int unsigned TargetW          = 24;
  localparam int unsigned SlotW            = 3;
  localparam int unsigned MaskW            = 8;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SlotW-1:0]   slot;
    logic [TargetW-1:0] target;
    logic               periodic;
  } stp_in_t;

  typedef struct packed {
    logic               status;
    logic [SlotW-1:0]   granted_slot;
    logic [MaskW-1:0]   expired_mask;
    logic [MaskW-1:0]   flag_mask;
    logic [MaskW-1:0]   active_mask;
  } stp_out_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic en;
    logic tick;
    logic alloc;
    logic free;
    logic clear;
    logic periodic;
  } cell_ctrl_t;

  // What a cell reports back (next-state view, plus activity before the step)
  typedef struct packed {
    logic active;
    logic busy;
    logic flag;
    logic expired;
    logic grant;
  } cell_stat_t;

endpackage

// File: hw/rtl/software_timer_pool.sv
// ----------------------------------------------------------------------------
// software_timer_pool
// Pool of one-shot and periodic timer slots built as a chain of slot cells.
// ----------------------------------------------------------------------------
// One request per clock while the result register is empty or being emptied: a
// transaction is taken only then, every cell updates in that same cycle, and the
// result appears registered in the next cycle. The longest path is the free-slot
// token rippling through all SLOTS cells on an allocate, next to each cell's count
// increment and compare. Masks and granted_slot show slots 0..7 only.
module software_timer_pool import stp_pkg::*; #(
  parameter int unsigned SLOTS      = SlotsDefault,
  parameter int unsigned LIMIT_BITS = LimitBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stp_out_t out_data_o
);

  localparam int unsigned ShownSlots = (SLOTS < MaskW) ? SLOTS : MaskW;

  logic                  accept;
  logic                  out_valid_q;
  stp_out_t              out_q, out_d;
  cell_ctrl_t            ctrl;
  req_e                  req;
  logic [SLOTS:0]        found;
  logic [SLOTS-1:0]      sel;
  cell_stat_t            stat [SLOTS];

  assign req        = req_e'(in_data_i.req_type);
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign ctrl = '{en:       accept,
                  tick:     req == REQ_TICK,
                  alloc:    req == REQ_ALLOC,
                  free:     req == REQ_FREE,
                  clear:    req == REQ_CLEAR,
                  periodic: in_data_i.periodic};

  assign found[0] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i < MaskW) begin : g_sel
      assign sel[i] = (in_data_i.slot == SlotW'(i));
    end else begin : g_nosel
      assign sel[i] = 1'b0;
    end

    stp_cell #(
      .LIMIT_BITS(LIMIT_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sel_i   (sel[i]),
      .target_i(in_data_i.target),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .stat_o  (stat[i])
    );
  end

  always_comb begin
    logic             any_grant;
    logic             sel_active;
    logic             sel_any;
    logic [SlotW-1:0] gslot;
    any_grant  = 1'b0;
    sel_active = 1'b0;
    sel_any    = |sel;
    gslot      = '0;
    out_d      = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_grant = any_grant | stat[i].grant;
      if (stat[i].grant) begin
        gslot = gslot | SlotW'(i);
      end
    end
    // a free only succeeds on a slot that was active before the step
    for (int i = 0; i < SLOTS; i++) begin
      sel_active = sel_active | (sel[i] & stat[i].busy);
    end
    for (int i = 0; i < ShownSlots; i++) begin
      out_d.expired_mask[i] = stat[i].expired;
      out_d.flag_mask[i]    = stat[i].flag;
      out_d.active_mask[i]  = stat[i].active;
    end
    out_d.granted_slot = gslot;
    unique case (req)
      REQ_TICK:  out_d.status = 1'b0;
      REQ_ALLOC: out_d.status = ~any_grant;
      REQ_FREE:  out_d.status = ~sel_active;
      REQ_CLEAR: out_d.status = ~sel_any;
      default:   out_d.status = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/stp_cell.sv
// ----------------------------------------------------------------------------
// stp_cell
// One timer slot: count, limit, mode, active and overflow flag. Passes the
// "free slot already found" token to the next cell in the chain.
// ----------------------------------------------------------------------------
module stp_cell import stp_pkg::*; #(
  parameter int unsigned LIMIT_BITS = LimitBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  sel_i,
  input  logic [TargetW-1:0]    target_i,
  input  logic                  found_i,
  output logic                  found_o,
  output cell_stat_t            stat_o
);

  localparam int unsigned CountW = LIMIT_BITS + 1;

  logic                  active_q, active_d;
  logic                  flag_q, flag_d;
  logic                  reload_q, reload_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [LIMIT_BITS-1:0] limit_q, limit_d;
  logic [CountW-1:0]     count_inc;
  logic                  grant;
  logic                  expired;

  assign grant     = ctrl_i.alloc & ~active_q & ~found_i;
  assign found_o   = found_i | ~active_q;
  assign count_inc = count_q + CountW'(1);
  assign expired   = ctrl_i.tick & active_q & (count_inc > CountW'(limit_q));

  always_comb begin
    active_d = active_q;
    flag_d   = flag_q;
    reload_d = reload_q;
    count_d  = count_q;
    limit_d  = limit_q;
    if (ctrl_i.tick && active_q) begin
      if (expired) begin
        flag_d = 1'b1;
        if (reload_q) begin
          count_d = CountW'(1);
        end else begin
          active_d = 1'b0;
        end
      end else begin
        count_d = count_inc;
      end
    end
    if (grant) begin
      active_d = 1'b1;
      flag_d   = 1'b0;
      count_d  = '0;
      limit_d  = LIMIT_BITS'(target_i);
      reload_d = ctrl_i.periodic;
    end
    if (ctrl_i.free && sel_i) begin
      active_d = 1'b0;
    end
    if (ctrl_i.clear && sel_i) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      flag_q   <= 1'b0;
    end else if (ctrl_i.en) begin
      active_q <= active_d;
      flag_q   <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      reload_q <= reload_d;
      count_q  <= count_d;
      limit_q  <= limit_d;
    end
  end

  assign stat_o = '{active: active_d, busy: active_q, flag: flag_d, expired: expired,
                    grant: grant};

endmodule

// File: hw/rtl/stp_checker.sv
// ----------------------------------------------------------------------------
// stp_props
// Port-level checks for the software timer pool, bound to the top level.
// ----------------------------------------------------------------------------
module stp_props import stp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input stp_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input stp_out_t out_data_o
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Every accepted transaction yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted transaction");

  // Only ticks report expiry
  a_expiry_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type != REQ_TICK)
      |=> out_data_o.expired_mask == '0)
    else $error("expiry reported on a non-tick request");

  // An expired slot always carries its overflow flag
  a_expired_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.expired_mask & ~out_data_o.flag_mask) == '0)
    else $error("expired slot without overflow flag");

  // A nonzero grant only comes with a good status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.granted_slot != '0) |-> !out_data_o.status)
    else $error("slot granted with error status");

endmodule

bind software_timer_pool stp_props u_stp_props (.*);

// File: bench/stp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stp_checker
// Watches both channels of the timer pool, keeps its own copy of the slot
// state, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module stp_checker import stp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  stp_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  stp_out_t out_data_i,
  output int       errors_o,
  output int       pending_o,
  output int       requests_o,
  output int       expiries_o
);

  localparam int unsigned Slots = SlotsDefault;
  localparam int unsigned CountW = LimitBitsDefault + 1;

  logic                        slot_busy [Slots];
  logic [CountW-1:0]           tick_count[Slots];
  logic [LimitBitsDefault-1:0] limit_q   [Slots];
  logic                        reload_q  [Slots];
  logic                        overflow_q[Slots];

  stp_out_t expected_q[$];
  stp_out_t want;
  int errors;
  int requests;
  int expiries;

  assign errors_o   = errors;
  assign pending_o  = expected_q.size();
  assign requests_o = requests;
  assign expiries_o = expiries;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] timer pool mismatch: %s", $time, msg);
  endtask

  // Applies one transaction to the slot state and returns the result it gives
  task automatic step_pool(input stp_in_t req, output stp_out_t res);
    logic found;
    res = '0;
    found = 1'b0;
    case (req_e'(req.req_type))
      REQ_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_busy[i]) begin
            tick_count[i] = tick_count[i] + 1'b1;
            if (tick_count[i] > CountW'(limit_q[i])) begin
              overflow_q[i] = 1'b1;
              res.expired_mask[i] = 1'b1;
              if (reload_q[i]) begin
                tick_count[i] = CountW'(1);
              end else begin
                slot_busy[i] = 1'b0;
              end
            end
          end
        end
      end
      REQ_ALLOC: begin
        res.status = 1'b1;
        for (int i = 0; i < Slots; i++) begin
          if (!found && !slot_busy[i]) begin
            found = 1'b1;
            slot_busy[i]  = 1'b1;
            tick_count[i] = '0;
            overflow_q[i] = 1'b0;
            limit_q[i]    = req.target[LimitBitsDefault-1:0];
            reload_q[i]   = req.periodic;
            res.status    = 1'b0;
            res.granted_slot = SlotW'(i);
          end
        end
      end
      REQ_FREE: begin
        if (slot_busy[req.slot]) begin
          slot_busy[req.slot] = 1'b0;
        end else begin
          res.status = 1'b1;
        end
      end
      default: begin
        // clear drops the flag even on an idle slot
        overflow_q[req.slot] = 1'b0;
      end
    endcase
    for (int i = 0; i < Slots; i++) begin
      res.flag_mask[i]   = overflow_q[i];
      res.active_mask[i] = slot_busy[i];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slot_busy[i]  = 1'b0;
        tick_count[i] = '0;
        limit_q[i]    = '0;
        reload_q[i]   = 1'b0;
        overflow_q[i] = 1'b0;
      end
      expected_q.delete();
      errors   = 0;
      requests = 0;
      expiries = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        step_pool(in_data_i, want);
        expected_q.push_back(want);
        requests++;
        expiries += $countones(want.expired_mask);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with nothing outstanding", out_data_i));
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch($sformatf("status %0b, expected %0b",
                                      out_data_i.status, want.status));
          if (out_data_i.granted_slot !== want.granted_slot)
            report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                      out_data_i.granted_slot, want.granted_slot));
          if (out_data_i.expired_mask !== want.expired_mask)
            report_mismatch($sformatf("expired_mask %b, expected %b",
                                      out_data_i.expired_mask, want.expired_mask));
          if (out_data_i.flag_mask !== want.flag_mask)
            report_mismatch($sformatf("flag_mask %b, expected %b",
                                      out_data_i.flag_mask, want.flag_mask));
          if (out_data_i.active_mask !== want.active_mask)
            report_mismatch($sformatf("active_mask %b, expected %b",
                                      out_data_i.active_mask, want.active_mask));
        end
      end
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the timer pool with a directed opening and a long random mix of
// tick, allocate, free and clear transactions under random back-pressure;
// the checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import stp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomRequests = 650;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  stp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  stp_out_t out_data;

  int errors;
  int pending;
  int requests;
  int expiries;
  int idle_cycles;
  int stall_left;
  int calm_left;

  software_timer_pool u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  stp_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .requests_o (requests),
    .expiries_o (expiries)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stp_in_t mk_request(req_e kind, int slot, logic [23:0] target,
                                         logic periodic);
    stp_in_t req;
    req.req_type = kind;
    req.slot     = SlotW'(slot);
    req.target   = target;
    req.periodic = periodic;
    return req;
  endfunction

  function automatic stp_in_t rand_request();
    stp_in_t req;
    int r;
    r = $urandom_range(0, 99);
    req.slot     = SlotW'($urandom_range(0, 7));
    req.target   = TargetW'($urandom);
    req.periodic = 1'($urandom_range(0, 1));
    if (r < 45) begin
      req.req_type = REQ_TICK;
    end else if (r < 68) begin
      req.req_type = REQ_ALLOC;
      r = $urandom_range(0, 99);
      // short targets so that slots actually expire
      if (r < 75) req.target = TargetW'($urandom_range(0, 6));
      else if (r < 92) req.target = TargetW'($urandom_range(7, 300));
    end else if (r < 84) begin
      req.req_type = REQ_FREE;
    end else begin
      req.req_type = REQ_CLEAR;
    end
    return req;
  endfunction

  task automatic send_request(input stp_in_t req, input bit burst);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver back-pressure, with calm stretches of constant ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(20, 120);
      else if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stp_in_t plan[$];
    bit burst;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back(mk_request(REQ_TICK,  0, 24'h000000, 1'b0)); // empty pool
    plan.push_back(mk_request(REQ_FREE,  3, 24'h000000, 1'b0)); // idle slot
    plan.push_back(mk_request(REQ_CLEAR, 5, 24'h000000, 1'b0));
    plan.push_back(mk_request(REQ_ALLOC, 0, 24'h000000, 1'b0)); // one-shot, zero target
    plan.push_back(mk_request(REQ_ALLOC, 7, 24'hFFFFFF, 1'b1));
    plan.push_back(mk_request(REQ_ALLOC, 0, 24'h000001, 1'b1));
    plan.push_back(mk_request(REQ_TICK,  7, 24'hFFFFFF, 1'b1)); // one-shot frees itself
    plan.push_back(mk_request(REQ_TICK,  0, 24'h000000, 1'b0)); // periodic reload
    plan.push_back(mk_request(REQ_CLEAR, 0, 24'h000000, 1'b0)); // flag kept after free
    plan.push_back(mk_request(REQ_FREE,  1, 24'h000000, 1'b0));
    plan.push_back(mk_request(REQ_FREE,  1, 24'h000000, 1'b0)); // already free
    for (int i = 0; i < 7; i++)
      plan.push_back(mk_request(REQ_ALLOC, i, 24'h000002, i[0]));
    plan.push_back(mk_request(REQ_ALLOC, 0, 24'h000000, 1'b0)); // pool full
    repeat (3) plan.push_back(mk_request(REQ_TICK, 0, 24'h000000, 1'b0));
    plan.push_back(mk_request(REQ_CLEAR, 7, 24'h000000, 1'b1));
    plan.push_back(mk_request(REQ_FREE,  0, 24'h000000, 1'b0));
    plan.push_back(mk_request(REQ_ALLOC, 2, 24'hAAAAAA, 1'b1));

    foreach (plan[i]) send_request(plan[i], 1'b0);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      send_request(rand_request(), burst);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("covered %0d transactions with %0d slot expiries, %0d mismatches",
             requests, expiries, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
